// ===== sv/sbba_pkg.sv =====
// constants, tables and types shared by the striped bitmap block allocator
`timescale 1ns / 1ps
`default_nettype none

package sbba_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned BIT_W     = 6;
  localparam int unsigned DIV_SHIFT = 9;

  localparam logic [0:0] OP_FORMAT = 1'b0;
  localparam logic [0:0] OP_ALLOC  = 1'b1;

  localparam logic [0:0] CFG_NUM_DISKS   = 1'b0;
  localparam logic [0:0] CFG_DISK_BLOCKS = 1'b1;

  localparam logic [3:0]  NUM_DISKS_RST   = 4'd1;
  localparam logic [15:0] DISK_BLOCKS_RST = 16'd32000;

  // ceil(2^9 / d) for d = 1..8, exact quotient of a bit position by d
  localparam logic [9:0] RECIP [8] = '{
    10'd512, 10'd256, 10'd171, 10'd128, 10'd103, 10'd86, 10'd74, 10'd64
  };

  // one word of blocks split by d: quotient and remainder for d = 1..8
  localparam logic [6:0] STEP_Q [8] = '{
    7'd64, 7'd32, 7'd21, 7'd16, 7'd12, 7'd10, 7'd9, 7'd8
  };
  localparam logic [2:0] STEP_R [8] = '{
    3'd0, 3'd0, 3'd1, 3'd0, 3'd4, 3'd4, 3'd1, 3'd0
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FMT,
    ST_RD,
    ST_LOAD,
    ST_FIND,
    ST_DIV,
    ST_REM,
    ST_PUSH,
    ST_WB,
    ST_FLUSH
  } state_e;

endpackage

`default_nettype wire

// ===== sv/striped_bitmap_block_allocator.sv =====
// first-fit free block allocator over a striped bitmap held in one word memory
`timescale 1ns / 1ps
`default_nettype none

// The free map lives in a single-port memory of 64-bit words, one bit per block.
// After reset no block is free until the first format request. A format writes
// one word per cycle through the whole map before its single acknowledge. An
// allocate reads the map word by word from block 0, so its time follows how
// full the low part of the map is. Only one request is worked on at a time; the
// next request is taken as soon as the last result sits in the output register.
// Disk and sector come from the global index divided by the disk count.
module striped_bitmap_block_allocator #(
  parameter int unsigned MAX_BLOCKS  = 262144,
  parameter int unsigned MAX_REQUEST = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // blocks_needed[6:0], zero pad
  input  wire logic        s_axis_tuser,   // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // block_index[17:0], disk_number[20:18],
                                           // sector[35:21], zero pad
  output logic             m_axis_tuser,   // found
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);

  import sbba_pkg::*;

  localparam int unsigned NUM_WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned TOTW      = ($clog2(MAX_BLOCKS + 1) > 20) ?
                                      $clog2(MAX_BLOCKS + 1) : 20;
  localparam int unsigned IW        = AW + BIT_W;
  localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

  state_e state_q, state_d;

  logic [3:0]        num_disks_q;
  logic [15:0]       disk_blocks_q;
  logic              map_valid_q;
  logic [6:0]        need_q;
  logic [6:0]        count_q;
  logic              pend_valid_q;
  logic              out_valid_q;

  logic [TOTW-1:0]   total_q;
  logic [AW-1:0]     word_q;
  logic [WORD_W-1:0] bits_q;
  logic [BIT_W-1:0]  bitpos_q;
  logic [5:0]        qbit_q;
  logic [2:0]        rbit_q;
  logic [2:0]        base_disk_q;
  logic [14:0]       base_sec_q;
  logic [17:0]       pend_idx_q;
  logic [2:0]        pend_disk_q;
  logic [14:0]       pend_sec_q;
  logic [39:0]       out_data_q;
  logic              out_found_q;
  logic              out_last_q;

  logic [WORD_W-1:0] map_mem [NUM_WORDS];
  logic [WORD_W-1:0] mem_rdata_q;

  logic              in_accept;
  logic              out_free;
  logic              mem_we;
  logic              mem_re;
  logic [WORD_W-1:0] mem_wdata;
  logic              out_load;
  logic [39:0]       out_data_d;
  logic              out_found_d;
  logic              out_last_d;

  logic [2:0]        dm1;
  logic [3:0]        d_eff;
  logic [6:0]        need_sat;
  logic [19:0]       prod;
  logic [TOTW-1:0]   prod_ext;
  logic [TOTW-1:0]   total_cap;
  logic [AW+TOTW-1:0] w_ext;
  logic [AW+TOTW-1:0] tw_ext;
  logic [WORD_W-1:0] fmt_word;
  logic [BIT_W-1:0]  low_pos;
  logic [15:0]       qm;
  logic [9:0]        qd;
  logic [9:0]        rem10;
  logic [IW-1:0]     idx_full;
  logic [IW+17:0]    idx_wide;
  logic [3:0]        r_sum;
  logic              r_wrap;
  logic [2:0]        new_disk;
  logic [14:0]       new_sec;
  logic [3:0]        s_sum;
  logic              s_wrap;
  logic [2:0]        step_disk;
  logic [14:0]       step_sec;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;

  // effective disk count, 0 acts as 1 and anything above 8 as 8
  always_comb begin
    if (num_disks_q == 4'd0) begin
      dm1 = 3'd0;
    end else if (num_disks_q > 4'd8) begin
      dm1 = 3'd7;
    end else begin
      dm1 = 3'(num_disks_q - 4'd1);
    end
    d_eff = {1'b0, dm1} + 4'd1;
  end

  always_comb begin
    need_sat  = (s_axis_tdata[6:0] > 7'(MAX_REQUEST)) ? 7'(MAX_REQUEST) : s_axis_tdata[6:0];
    prod      = {16'd0, d_eff} * {4'd0, disk_blocks_q};
    prod_ext  = TOTW'(prod);
    total_cap = (prod_ext > TOTW'(MAX_BLOCKS)) ? TOTW'(MAX_BLOCKS) : prod_ext;
  end

  // format word: all free below the total, partial word at the boundary
  always_comb begin
    w_ext  = {{TOTW{1'b0}}, word_q};
    tw_ext = {{(AW + BIT_W){1'b0}}, total_q[TOTW-1:BIT_W]};
    if (w_ext < tw_ext) begin
      fmt_word = '1;
    end else if (w_ext == tw_ext) begin
      fmt_word = (WORD_W'(1) << total_q[BIT_W-1:0]) - WORD_W'(1);
    end else begin
      fmt_word = '0;
    end
  end

  always_comb begin
    low_pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (bits_q[i]) begin
        low_pos = BIT_W'(i);
      end
    end
  end

  // bit position split by d, then merged with the running word base
  always_comb begin
    qm       = {10'd0, bitpos_q} * {6'd0, RECIP[dm1]};
    qd       = {4'd0, qbit_q} * {6'd0, d_eff};
    rem10    = {4'd0, bitpos_q} - qd;
    idx_full = {word_q, bitpos_q};
    idx_wide = {18'd0, idx_full};
    r_sum    = {1'b0, base_disk_q} + {1'b0, rbit_q};
    r_wrap   = (r_sum >= d_eff);
    new_disk = r_wrap ? 3'(r_sum - d_eff) : r_sum[2:0];
    new_sec  = base_sec_q + {9'd0, qbit_q} + {14'd0, r_wrap};
    s_sum    = {1'b0, base_disk_q} + {1'b0, STEP_R[dm1]};
    s_wrap   = (s_sum >= d_eff);
    step_disk = s_wrap ? 3'(s_sum - d_eff) : s_sum[2:0];
    step_sec  = base_sec_q + {8'd0, STEP_Q[dm1]} + {14'd0, s_wrap};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (s_axis_tuser == OP_FORMAT) begin
            state_d = ST_FMT;
          end else if (need_sat == 7'd0) begin
            state_d = ST_FLUSH;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_FMT: begin
        if (word_q == LAST_WORD) begin
          state_d = ST_FLUSH;
        end
      end
      ST_RD:   state_d = ST_LOAD;
      ST_LOAD: state_d = ST_FIND;
      ST_FIND: begin
        state_d = (bits_q != '0) ? ST_DIV : ST_WB;
      end
      ST_DIV:  state_d = ST_REM;
      ST_REM:  state_d = ST_PUSH;
      ST_PUSH: begin
        if (!pend_valid_q || out_free) begin
          state_d = (count_q == need_q) ? ST_WB : ST_FIND;
        end
      end
      ST_WB: begin
        state_d = ((count_q == need_q) || (word_q == LAST_WORD)) ? ST_FLUSH : ST_RD;
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    mem_we        = (state_q == ST_FMT) || (state_q == ST_WB);
    mem_wdata     = (state_q == ST_FMT) ? fmt_word : bits_q;
    mem_re        = (state_q == ST_RD);
    out_load      = 1'b0;
    out_data_d    = {4'd0, pend_sec_q, pend_disk_q, pend_idx_q};
    out_found_d   = 1'b1;
    out_last_d    = 1'b0;
    case (state_q)
      ST_PUSH: begin
        out_load = pend_valid_q && out_free;
      end
      ST_FLUSH: begin
        out_load   = out_free;
        out_last_d = 1'b1;
        if (!pend_valid_q) begin
          out_data_d  = '0;
          out_found_d = 1'b0;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[word_q] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= map_mem[word_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      num_disks_q   <= NUM_DISKS_RST;
      disk_blocks_q <= DISK_BLOCKS_RST;
      map_valid_q   <= 1'b0;
      need_q        <= '0;
      count_q       <= '0;
      pend_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUM_DISKS:   num_disks_q   <= cfg_wdata_i[3:0];
          CFG_DISK_BLOCKS: disk_blocks_q <= cfg_wdata_i;
          default:         num_disks_q   <= num_disks_q;
        endcase
      end
      if (in_accept) begin
        need_q  <= need_sat;
        count_q <= '0;
      end
      if ((state_q == ST_FMT) && (word_q == LAST_WORD)) begin
        map_valid_q <= 1'b1;
      end
      if ((state_q == ST_FIND) && (bits_q != '0)) begin
        count_q <= count_q + 7'd1;
      end
      if ((state_q == ST_PUSH) && (!pend_valid_q || out_free)) begin
        pend_valid_q <= 1'b1;
      end
      if ((state_q == ST_FLUSH) && out_free) begin
        pend_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      total_q     <= total_cap;
      word_q      <= '0;
      base_disk_q <= '0;
      base_sec_q  <= '0;
    end
    case (state_q)
      ST_FMT: begin
        if (word_q != LAST_WORD) begin
          word_q <= word_q + AW'(1);
        end
      end
      ST_LOAD: begin
        bits_q <= map_valid_q ? mem_rdata_q : '0;
      end
      ST_FIND: begin
        if (bits_q != '0) begin
          bitpos_q <= low_pos;
          bits_q   <= bits_q & (bits_q - WORD_W'(1));
        end
      end
      ST_DIV: begin
        qbit_q <= qm[DIV_SHIFT+5:DIV_SHIFT];
      end
      ST_REM: begin
        rbit_q <= rem10[2:0];
      end
      ST_PUSH: begin
        if (!pend_valid_q || out_free) begin
          pend_idx_q  <= idx_wide[17:0];
          pend_disk_q <= new_disk;
          pend_sec_q  <= new_sec;
        end
      end
      ST_WB: begin
        if ((count_q != need_q) && (word_q != LAST_WORD)) begin
          word_q      <= word_q + AW'(1);
          base_disk_q <= step_disk;
          base_sec_q  <= step_sec;
        end
      end
      default: begin
        bitpos_q <= bitpos_q;
      end
    endcase
    if (out_load) begin
      out_data_q  <= out_data_d;
      out_found_q <= out_found_d;
      out_last_q  <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking testbench for the striped bitmap block allocator
`timescale 1ns / 1ps

module testbench;
  import sbba_pkg::*;

  localparam int unsigned MAP_SIZE    = 262144;
  localparam int unsigned MAX_TAKE    = 64;
  localparam int unsigned QUIET_LIMIT = 50000;

  typedef struct packed {
    logic [17:0] block_index;
    logic [2:0]  disk_number;
    logic [14:0] sector;
    logic        found;
    logic        last;
  } alloc_result_t;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_e;

  bit          clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // blocks_needed[6:0], zero pad
  logic        s_axis_tuser;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // block_index[17:0], disk_number[20:18], sector[35:21], pad
  logic        m_axis_tuser;   // found
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  bit            free_map [MAP_SIZE];
  int unsigned   free_left;
  logic [3:0]    disks_cfg;
  logic [15:0]   blocks_per_disk;
  alloc_result_t expected_blocks [$];

  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  int unsigned burst_left;
  int unsigned sink_hold_cycles;
  int unsigned full_scans_left;

  striped_bitmap_block_allocator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned disk_count();
    if (disks_cfg == 4'd0) return 1;
    if (disks_cfg > 4'd8) return 8;
    return int'(disks_cfg);
  endfunction

  function automatic void expect_result(input alloc_result_t r);
    expected_blocks = {expected_blocks, r};
  endfunction

  task automatic predict_allocation(input logic [0:0] op, input logic [6:0] need);
    int unsigned d, total, want, got, idx;
    alloc_result_t pick, r;
    d = disk_count();
    r = '0;
    pick = '0;
    got = 0;
    if (op == OP_FORMAT) begin
      total = d * int'(blocks_per_disk);
      if (total > MAP_SIZE) total = MAP_SIZE;
      for (idx = 0; idx < MAP_SIZE; idx++) free_map[idx] = (idx < total);
      free_left = total;
      r.last = 1'b1;
      expect_result(r);
    end else begin
      want = (need > MAX_TAKE) ? MAX_TAKE : int'(need);
      for (idx = 0; idx < MAP_SIZE && got < want; idx++) begin
        if (free_map[idx]) begin
          if (got != 0) expect_result(pick);
          free_map[idx] = 1'b0;
          got++;
          pick.block_index = idx[17:0];
          pick.disk_number = 3'(idx % d);
          pick.sector      = 15'(idx / d);
          pick.found       = 1'b1;
          pick.last        = 1'b0;
        end
      end
      free_left -= got;
      if (got == 0) begin
        r.last = 1'b1;
        expect_result(r);
      end else begin
        pick.last = 1'b1;
        expect_result(pick);
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic send_request(input logic [0:0] op, input logic [6:0] need);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, need};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_allocation(op, need);
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_NUM_DISKS) disks_cfg = value[3:0];
    else blocks_per_disk = value;
  endtask

  // result checker
  always @(posedge clk_i) begin
    alloc_result_t seen, want;
    if (m_axis_tvalid && m_axis_tready) begin
      seen = {m_axis_tdata[17:0], m_axis_tdata[20:18], m_axis_tdata[35:21],
              m_axis_tuser, m_axis_tlast};
      if (expected_blocks.size() == 0) begin
        report_mismatch($sformatf("unexpected result index %0d", seen.block_index));
      end else begin
        want = expected_blocks.pop_front();
        if (seen.block_index != want.block_index)
          report_mismatch($sformatf("block_index %0d, want %0d",
                                    seen.block_index, want.block_index));
        if (seen.disk_number != want.disk_number)
          report_mismatch($sformatf("disk_number %0d, want %0d",
                                    seen.disk_number, want.disk_number));
        if (seen.sector != want.sector)
          report_mismatch($sformatf("sector %0d, want %0d", seen.sector, want.sector));
        if (seen.found != want.found)
          report_mismatch($sformatf("found %0b, want %0b", seen.found, want.found));
        if (seen.last != want.last)
          report_mismatch($sformatf("last %0b, want %0b", seen.last, want.last));
        if (m_axis_tdata[39:36] != 4'd0)
          report_mismatch($sformatf("pad bits %h not zero", m_axis_tdata[39:36]));
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // result sink with its own stall pattern and long hold-offs on request
  initial begin : result_sink
    rx_mode_e    mode;
    int unsigned mode_left, tick, k;
    mode = RX_ALWAYS;
    mode_left = 0;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        for (k = 1; k < sink_hold_cycles; k++) @(negedge clk_i);
        sink_hold_cycles = 0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 160);
        end
        mode_left--;
        tick++;
        case (mode)
          RX_ALWAYS: m_axis_tready <= 1'b1;
          RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_axis_tready <= ($urandom_range(0, 4) == 0);
          default:   m_axis_tready <= (tick % 3 != 0);
        endcase
      end
    end
  end

  task automatic test_before_format();
    send_request(OP_ALLOC, 7'd5);
  endtask

  task automatic test_default_format();
    send_request(OP_FORMAT, 7'd0);
    send_request(OP_ALLOC, 7'd1);
    send_request(OP_ALLOC, 7'd64);
    send_request(OP_ALLOC, 7'd127);
    send_request(OP_ALLOC, 7'd0);
  endtask

  task automatic test_striping();
    settle();
    write_reg(CFG_NUM_DISKS, 16'd3);
    write_reg(CFG_DISK_BLOCKS, 16'd5);
    send_request(OP_FORMAT, 7'd0);
    send_request(OP_ALLOC, 7'd7);
    send_request(OP_ALLOC, 7'd10);
    send_request(OP_ALLOC, 7'd2);
  endtask

  task automatic test_config_extremes();
    settle();
    write_reg(CFG_NUM_DISKS, 16'd0);
    write_reg(CFG_DISK_BLOCKS, 16'd0);
    send_request(OP_FORMAT, 7'd0);
    send_request(OP_ALLOC, 7'd1);
    settle();
    write_reg(CFG_NUM_DISKS, 16'hffff);
    write_reg(CFG_DISK_BLOCKS, 16'hffff);
    send_request(OP_FORMAT, 7'd0);
    send_request(OP_ALLOC, 7'd85);
    settle();
    write_reg(CFG_NUM_DISKS, 16'd5);
    send_request(OP_ALLOC, 7'd42);
    settle();
    write_reg(CFG_NUM_DISKS, 16'd7);
    write_reg(CFG_DISK_BLOCKS, 16'd1);
    send_request(OP_FORMAT, 7'd0);
    send_request(OP_ALLOC, 7'd64);
  endtask

  task automatic test_backpressure();
    settle();
    write_reg(CFG_NUM_DISKS, 16'd4);
    write_reg(CFG_DISK_BLOCKS, 16'd1000);
    send_request(OP_FORMAT, 7'd0);
    settle();
    sink_hold_cycles = 400;
    send_request(OP_ALLOC, 7'd64);
    send_request(OP_ALLOC, 7'd64);
    send_request(OP_ALLOC, 7'd30);
    send_request(OP_ALLOC, 7'd64);
  endtask

  task automatic test_random_phases();
    int unsigned ph, n, pick, want;
    logic [6:0]  need;
    logic [0:0]  op;
    for (ph = 0; ph < 6; ph++) begin
      settle();
      if (ph == 0) begin
        write_reg(CFG_NUM_DISKS, 16'd8);
        write_reg(CFG_DISK_BLOCKS, 16'd32768);
      end else begin
        write_reg(CFG_NUM_DISKS, 16'($urandom_range(0, 15)));
        if (ph % 3 == 2) write_reg(CFG_DISK_BLOCKS, 16'($urandom_range(1, 12)));
        else write_reg(CFG_DISK_BLOCKS, 16'($urandom_range(1000, 65535)));
      end
      send_request(OP_FORMAT, 7'($urandom_range(0, 127)));
      for (n = 1; n < 16; n++) begin
        pick = $urandom_range(0, 19);
        op = OP_ALLOC;
        if (pick == 0) begin
          op = OP_FORMAT;
          need = 7'($urandom_range(0, 127));
        end else if (pick == 1) need = 7'd0;
        else if (pick == 2) need = 7'($urandom_range(65, 127));
        else need = 7'($urandom_range(1, 64));
        want = (need > MAX_TAKE) ? MAX_TAKE : int'(need);
        // a request larger than what is left scans the whole map, keep those rare
        if (op == OP_ALLOC && want > free_left) begin
          if (full_scans_left != 0) full_scans_left--;
          else if (free_left != 0) need = 7'(free_left);
          else op = OP_FORMAT;
        end
        send_request(op, need);
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = 1'b0;
    m_axis_tready   = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    disks_cfg       = NUM_DISKS_RST;
    blocks_per_disk = DISK_BLOCKS_RST;
    free_left       = 0;
    mismatch_count  = 0;
    burst_left      = 0;
    sink_hold_cycles = 0;
    full_scans_left = 8;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_before_format();
    test_default_format();
    test_striping();
    test_config_extremes();
    test_backpressure();
    test_random_phases();

    settle();
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sbba_pkg.sv
sv/striped_bitmap_block_allocator.sv
bench/testbench.sv
